/* src/voltage_average_and_smooth_unit_assert.svh */
// Assertion macros for the voltage averaging and smoothing unit.
// The macros expect signals named clk and rst_n in the scope where they are used.
`ifndef VOLTAGE_AVERAGE_AND_SMOOTH_UNIT_ASSERT_SVH
`define VOLTAGE_AVERAGE_AND_SMOOTH_UNIT_ASSERT_SVH

`ifndef SYNTH

// The condition must hold at every clock edge outside reset.
`define VAS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define VAS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`else

`define VAS_ASSERT(lbl, prop, msg)
`define VAS_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

/* src/vas_pkg.sv */
`timescale 1ns / 1ps

package vas_pkg;

  localparam int DefWindowLength      = 10;
  localparam int DefSamplesPerReading = 5;

  localparam int SampleW  = 12;
  localparam int ReadingW = 13;
  localparam int ResultW  = 17;
  localparam int ModeW    = 2;
  localparam int AlphaW   = 9;
  localparam int CfgAddrW = 1;
  localparam int ProdW    = 26;

  localparam logic [ModeW-1:0] ModePass   = 2'd0;
  localparam logic [ModeW-1:0] ModeWindow = 2'd1;
  localparam logic [ModeW-1:0] ModeEma    = 2'd2;

  localparam logic [CfgAddrW-1:0] RegMode  = 1'd0;
  localparam logic [CfgAddrW-1:0] RegAlpha = 1'd1;

  localparam logic [AlphaW-1:0] AlphaReset = 9'd51;
  localparam logic [AlphaW-1:0] AlphaOne   = 9'd256;

  typedef enum logic [3:0] {
    S_IDLE,
    S_GRP_DIV,
    S_ROUTE,
    S_WIN_UPD,
    S_WIN_CHK,
    S_WIN_DIV,
    S_EMA_MUL,
    S_EMA_ADD,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

/* src/vas_div.sv */
`timescale 1ns / 1ps

module vas_div #(
  parameter int DW = 21,
  parameter int VW = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [DW-1:0]      dividend,
  input  logic [VW-1:0]      divisor,
  output vas_pkg::div_stat_t stat,
  output logic [DW-1:0]      quotient
);

  localparam int CntW = $clog2(DW + 1);

  logic            busy_r, busy_nxt;
  logic            done_r, done_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic [DW-1:0]   dvd_r, dvd_nxt;
  logic [VW-1:0]   rem_r, rem_nxt;
  logic [VW-1:0]   dvs_r, dvs_nxt;

  logic [VW:0] r_shift;
  logic [VW:0] r_sub;
  logic        ge;

  // Restoring division, one quotient bit per cycle; quotient bits shift in
  // from the bottom while dividend bits leave at the top.
  always_comb begin
    r_shift  = {rem_r, dvd_r[DW-1]};
    ge       = (r_shift >= {1'b0, dvs_r});
    r_sub    = r_shift - {1'b0, dvs_r};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CntW'(DW);
      dvd_nxt  = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      dvd_nxt = {dvd_r[DW-2:0], ge};
      rem_nxt = ge ? r_sub[VW-1:0] : r_shift[VW-1:0];
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CntW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quotient  = dvd_r;

endmodule

/* src/voltage_average_and_smooth_unit.sv */
// Voltage averaging and smoothing unit.
// Input stream: one calibrated sample per request, in_tdata[11:0] in millivolts.
// Every SAMPLES_PER_READING samples the group mean is doubled into a reading,
// smoothed by the mode in cfg register 0 (0 pass, 1 window mean, 2 EMA with
// the Q8 weight in register 1) and sent as one Q4 millivolt result on
// out_tdata[16:0]. Samples that do not close a group produce no result.
// A non-closing sample leaves in_tready high. A closing sample holds in_tready
// low while its result is formed: group division and routing, then the EMA
// seed or blend step, or the window update and check with, when the window
// holds a positive entry, the one-bit-per-cycle divider, or nothing more in
// pass-through, and last the emit state, which waits for the output register.
// The window ring sits in a one-port synchronous memory updated by
// read-modify-write, with a running total and positive-entry count in flops.
// Reset clears the group accumulator, the ring (per-entry valid bits), the EMA
// state and sets mode 0 and weight 51; no clearing pass is needed.
// A result waits in the output register while the receiver stalls; new samples
// are still taken, and the next result is held back until that register frees.
`timescale 1ns / 1ps
`include "voltage_average_and_smooth_unit_assert.svh"

module voltage_average_and_smooth_unit #(
  parameter int WINDOW_LENGTH       = vas_pkg::DefWindowLength,
  parameter int SAMPLES_PER_READING = vas_pkg::DefSamplesPerReading
) (
  input  logic        clk,
  input  logic        rst_n,
  // sample_mv [11:0]
  input  logic [15:0] in_tdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  // smoothed_voltage_q4 [16:0]
  output logic [23:0] out_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  input  logic        cfg_we,
  input  logic [vas_pkg::CfgAddrW-1:0] cfg_addr,
  input  logic [vas_pkg::AlphaW-1:0]   cfg_wdata
);

  localparam int W    = WINDOW_LENGTH;
  localparam int Spr  = SAMPLES_PER_READING;
  localparam int CW   = $clog2(W + 1);
  localparam int TW   = vas_pkg::ReadingW + CW;
  localparam int PW   = (W > 1) ? $clog2(W) : 1;
  localparam int GSW  = $clog2(4095 * Spr + 1);
  localparam int GCW  = $clog2(Spr + 1);
  localparam int DivW = TW + 4;
  localparam int VW   = CW;
  // Scaled reciprocal of the group length; the extra shift makes the
  // product exact for every group sum.
  localparam int RecSh = GSW + $clog2(Spr);
  localparam int RecM  = ((1 << RecSh) + Spr - 1) / Spr;
  localparam int RecW  = $clog2(RecM + 1);
  localparam int GPW   = GSW + RecW;
  localparam int RW   = vas_pkg::ReadingW;
  localparam int QW   = vas_pkg::ResultW;
  localparam int PrW  = vas_pkg::ProdW;

  vas_pkg::state_t state_r, state_nxt;

  logic [vas_pkg::ModeW-1:0]  mode_r;
  logic [vas_pkg::AlphaW-1:0] alpha_r;

  logic [GSW-1:0] gsum_r, gsum_nxt;
  logic [GCW-1:0] gcnt_r, gcnt_nxt;
  logic [RW-1:0]  reading_r, reading_nxt;
  logic [QW-1:0]  res_r, res_nxt;
  logic [PrW-1:0] prod_r, prod_nxt;
  logic [QW-1:0]  ema_r, ema_nxt;
  logic [TW-1:0]  win_tot_r, win_tot_nxt;
  logic [CW-1:0]  win_cnt_r, win_cnt_nxt;
  logic [PW-1:0]  ptr_r, ptr_nxt;
  logic [W-1:0]   valid_r;
  logic [RW-1:0]  rdata_r;
  logic [RW-1:0]  win_mem [W];
  logic           mem_we;

  logic          out_valid_r, out_valid_nxt;
  logic [QW-1:0] out_data_r;
  logic          out_load;

  logic               div_start;
  logic [DivW-1:0]    div_dividend;
  logic [VW-1:0]      div_divisor;
  vas_pkg::div_stat_t div_stat;
  logic [DivW-1:0]    div_quot;

  logic                        in_acc;
  logic [RW-1:0]               old_entry;
  logic [QW-1:0]               fresh;
  logic [vas_pkg::AlphaW-1:0]  alpha_sat;
  logic [PrW-1:0]              ema_acc;
  logic [GPW-1:0]              grp_prod;
  logic [vas_pkg::SampleW-1:0] grp_mean;

  vas_div #(
    .DW (DivW),
    .VW (VW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .stat     (div_stat),
    .quotient (div_quot)
  );

  assign in_tready = (state_r == vas_pkg::S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign fresh     = {reading_r, 4'b0000};
  assign alpha_sat = (alpha_r > vas_pkg::AlphaOne) ? vas_pkg::AlphaOne : alpha_r;
  // An entry never written since reset reads as zero.
  assign old_entry = valid_r[ptr_r] ? rdata_r : '0;
  assign ema_acc   = prod_r + PrW'(vas_pkg::AlphaOne - alpha_sat) * PrW'(ema_r);
  assign grp_prod  = GPW'(gsum_r) * GPW'(RecM);
  assign grp_mean  = grp_prod[RecSh +: vas_pkg::SampleW];

  always_comb begin
    state_nxt    = state_r;
    gsum_nxt     = gsum_r;
    gcnt_nxt     = gcnt_r;
    reading_nxt  = reading_r;
    res_nxt      = res_r;
    prod_nxt     = prod_r;
    ema_nxt      = ema_r;
    win_tot_nxt  = win_tot_r;
    win_cnt_nxt  = win_cnt_r;
    ptr_nxt      = ptr_r;
    mem_we       = 1'b0;
    out_load     = 1'b0;
    div_start    = 1'b0;
    div_dividend = DivW'({win_tot_r, 4'b0000});
    div_divisor  = VW'(win_cnt_r);
    case (state_r)
      vas_pkg::S_IDLE: begin
        if (in_acc) begin
          gsum_nxt = gsum_r + GSW'(in_tdata[vas_pkg::SampleW-1:0]);
          if (gcnt_r == GCW'(Spr - 1)) begin
            gcnt_nxt  = '0;
            state_nxt = vas_pkg::S_GRP_DIV;
          end else begin
            gcnt_nxt = gcnt_r + 1'b1;
          end
        end
      end
      vas_pkg::S_GRP_DIV: begin
        // The group mean comes from the reciprocal product; doubling gives the reading.
        reading_nxt = {grp_mean, 1'b0};
        gsum_nxt    = '0;
        state_nxt   = vas_pkg::S_ROUTE;
      end
      vas_pkg::S_ROUTE: begin
        case (mode_r)
          vas_pkg::ModeWindow: state_nxt = vas_pkg::S_WIN_UPD;
          vas_pkg::ModeEma:    state_nxt = vas_pkg::S_EMA_MUL;
          default: begin
            res_nxt   = fresh;
            state_nxt = vas_pkg::S_EMIT;
          end
        endcase
      end
      vas_pkg::S_WIN_UPD: begin
        // The old entry leaves the running sums and the new reading enters.
        mem_we      = 1'b1;
        win_tot_nxt = win_tot_r - TW'(old_entry) + TW'(reading_r);
        win_cnt_nxt = win_cnt_r - CW'(old_entry != '0) + CW'(reading_r != '0);
        ptr_nxt     = (ptr_r == PW'(W - 1)) ? '0 : ptr_r + 1'b1;
        state_nxt   = vas_pkg::S_WIN_CHK;
      end
      vas_pkg::S_WIN_CHK: begin
        if (win_cnt_r == '0) begin
          res_nxt   = fresh;
          state_nxt = vas_pkg::S_EMIT;
        end else begin
          div_start = 1'b1;
          state_nxt = vas_pkg::S_WIN_DIV;
        end
      end
      vas_pkg::S_WIN_DIV: begin
        if (div_stat.done) begin
          res_nxt   = div_quot[QW-1:0];
          state_nxt = vas_pkg::S_EMIT;
        end
      end
      vas_pkg::S_EMA_MUL: begin
        if (ema_r == '0) begin
          ema_nxt   = fresh;
          res_nxt   = fresh;
          state_nxt = vas_pkg::S_EMIT;
        end else begin
          prod_nxt  = PrW'(alpha_sat) * PrW'(fresh);
          state_nxt = vas_pkg::S_EMA_ADD;
        end
      end
      vas_pkg::S_EMA_ADD: begin
        ema_nxt   = ema_acc[QW+7:8];
        res_nxt   = ema_acc[QW+7:8];
        state_nxt = vas_pkg::S_EMIT;
      end
      vas_pkg::S_EMIT: begin
        if (!out_valid_r || out_tready) begin
          out_load  = 1'b1;
          state_nxt = vas_pkg::S_IDLE;
        end
      end
      default: state_nxt = vas_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= vas_pkg::S_IDLE;
      mode_r      <= vas_pkg::ModePass;
      alpha_r     <= vas_pkg::AlphaReset;
      gsum_r      <= '0;
      gcnt_r      <= '0;
      ema_r       <= '0;
      win_tot_r   <= '0;
      win_cnt_r   <= '0;
      ptr_r       <= '0;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      gsum_r      <= gsum_nxt;
      gcnt_r      <= gcnt_nxt;
      ema_r       <= ema_nxt;
      win_tot_r   <= win_tot_nxt;
      win_cnt_r   <= win_cnt_nxt;
      ptr_r       <= ptr_nxt;
      out_valid_r <= out_valid_nxt;
      if (mem_we) begin
        valid_r[ptr_r] <= 1'b1;
      end
      if (cfg_we) begin
        case (cfg_addr)
          vas_pkg::RegMode:  mode_r  <= cfg_wdata[vas_pkg::ModeW-1:0];
          vas_pkg::RegAlpha: alpha_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    reading_r <= reading_nxt;
    res_r     <= res_nxt;
    prod_r    <= prod_nxt;
    if (out_load) begin
      out_data_r <= res_r;
    end
  end

  // Window ring: one write port and one registered read port at the pointer.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      win_mem[ptr_r] <= reading_r;
    end
    rdata_r <= win_mem[ptr_r];
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(24 - QW)'(0), out_data_r};

  `VAS_ASSERT(a_win_sum_count, (win_cnt_r == '0) == (win_tot_r == '0), "window sums disagree")
  `VAS_ASSERT(a_win_count_max, win_cnt_r <= CW'(W), "window count above window length")
  `VAS_ASSERT(a_div_start_free, !(div_start && div_stat.busy), "divider started while busy")
  `VAS_ASSERT_NEXT(a_out_drain, out_tvalid && out_tready && !out_load, !out_tvalid, "result repeated")

endmodule
